[rtl/lcs_pkg.sv]
// ---------------------------------------------------------------------------
// lcs_pkg
// shared widths and types for the linear congruence solver
// ---------------------------------------------------------------------------
package lcs_pkg;
	localparam int WORD_BITS = 32;
	localparam int CNT_W     = $clog2(WORD_BITS);

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	localparam cnt_t LAST_BIT = CNT_W'(WORD_BITS - 1);
endpackage

[rtl/lcs_div.sv]
// ---------------------------------------------------------------------------
// lcs_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module lcs_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           go,
	input  lcs_pkg::word_t dividend,
	input  lcs_pkg::word_t divisor,
	output logic           done,
	output lcs_pkg::word_t quo,
	output lcs_pkg::word_t rem
);
	import lcs_pkg::*;

	logic             run_q;
	logic             done_q;
	cnt_t             cnt_q;
	word_t            quo_q;
	word_t            dvs_q;
	logic [WORD_BITS:0] rem_q;
	logic [WORD_BITS:0] trial;
	logic [WORD_BITS:0] diff;
	logic             fits;

	assign trial = {rem_q[WORD_BITS-1:0], quo_q[WORD_BITS-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_BIT) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= fits ? diff : trial;
			quo_q <= {quo_q[WORD_BITS-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q[WORD_BITS-1:0];
endmodule

[rtl/lcs_mmul.sv]
// ---------------------------------------------------------------------------
// lcs_mmul
// modular multiplier, double-and-add over the multiplier bits, msb first
// ---------------------------------------------------------------------------
module lcs_mmul (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           go,
	input  lcs_pkg::word_t x,
	input  lcs_pkg::word_t y,
	input  lcs_pkg::word_t m,
	output logic           done,
	output lcs_pkg::word_t res
);
	import lcs_pkg::*;

	logic  run_q;
	logic  done_q;
	logic  ph_q;
	cnt_t  cnt_q;
	word_t x_q;
	word_t y_q;
	word_t m_q;
	word_t acc_q;
	logic [WORD_BITS:0] t;
	logic [WORD_BITS:0] t_red;

	// doubling phase, then conditional add phase
	always_comb begin
		if (!ph_q) begin
			t = {acc_q, 1'b0};
		end else begin
			t = {1'b0, acc_q} + (x_q[WORD_BITS-1] ? {1'b0, y_q} : '0);
		end
		t_red = (t >= {1'b0, m_q}) ? t - {1'b0, m_q} : t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			ph_q   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				ph_q  <= 1'b0;
				cnt_q <= '0;
			end else if (run_q) begin
				ph_q <= ~ph_q;
				if (ph_q) begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_BIT) begin
						run_q  <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			x_q   <= x;
			y_q   <= y;
			m_q   <= m;
			acc_q <= '0;
		end else if (run_q) begin
			acc_q <= t_red[WORD_BITS-1:0];
			if (ph_q) begin
				x_q <= {x_q[WORD_BITS-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign res  = acc_q;
endmodule

[rtl/linear_congruence_solver_top.sv]
// ---------------------------------------------------------------------------
// linear_congruence_solver_top
// solves coef * x = rhs (mod modulus) by gcd and extended euclid
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy stays high until
// the result is shown. The result appears on solvable and solution for exactly
// one cycle, marked by strobe, and must be taken then: there is no stall.
// All divisions and multiplications run through one restoring divider and one
// modular multiplier. A request costs about (g + 4) divisions for the gcd and
// reductions, k euclid steps of one division and one multiplication each, and a
// final division and multiplication, where g and k are the euclid step counts.
// A zero modulus is answered with no solution in the cycle after the request.
module linear_congruence_solver_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  lcs_pkg::word_t coef,
	input  lcs_pkg::word_t rhs,
	input  lcs_pkg::word_t modulus,
	output logic           strobe,
	output logic           solvable,
	output lcs_pkg::word_t solution
);
	import lcs_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_GCD  = 4'd1;
	localparam logic [3:0] S_BDIV = 4'd2;
	localparam logic [3:0] S_ADIV = 4'd3;
	localparam logic [3:0] S_NDIV = 4'd4;
	localparam logic [3:0] S_RED  = 4'd5;
	localparam logic [3:0] S_EUC  = 4'd6;
	localparam logic [3:0] S_MUL  = 4'd7;
	localparam logic [3:0] S_BRED = 4'd8;
	localparam logic [3:0] S_FIN  = 4'd9;

	logic [3:0] state_q;
	logic       strobe_q;
	logic       solvable_q;
	word_t      solution_q;

	logic  div_go_q, div_done;
	word_t div_a_q, div_b_q, div_quo, div_rem;
	logic  mul_go_q, mul_done;
	word_t mul_x_q, mul_y_q, mul_res;

	word_t a_q, b_q, n_q, y_q, rb_q, ra_q, m_q, or_q, r_q, os_q, s_q;
	word_t new_s;

	lcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go_q),
		.dividend (div_a_q),
		.divisor  (div_b_q),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	lcs_mmul u_mmul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go_q),
		.x      (mul_x_q),
		.y      (mul_y_q),
		.m      (m_q),
		.done   (mul_done),
		.res    (mul_res)
	);

	// old_s - q*s kept modulo m
	assign new_s = (os_q >= mul_res) ? os_q - mul_res : os_q - mul_res + m_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			strobe_q   <= 1'b0;
			solvable_q <= 1'b0;
			solution_q <= '0;
			div_go_q   <= 1'b0;
			mul_go_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			div_go_q <= 1'b0;
			mul_go_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (modulus == '0) begin
							strobe_q   <= 1'b1;
							solvable_q <= 1'b0;
							solution_q <= '0;
						end else begin
							div_go_q <= 1'b1;
							state_q  <= S_GCD;
						end
					end
				end
				S_GCD: begin
					if (div_done) begin
						div_go_q <= 1'b1;
						if (div_rem == '0) begin
							state_q <= S_BDIV;
						end
					end
				end
				S_BDIV: begin
					if (div_done) begin
						if (div_rem != '0) begin
							strobe_q   <= 1'b1;
							solvable_q <= 1'b0;
							solution_q <= '0;
							state_q    <= S_IDLE;
						end else begin
							div_go_q <= 1'b1;
							state_q  <= S_ADIV;
						end
					end
				end
				S_ADIV: begin
					if (div_done) begin
						div_go_q <= 1'b1;
						state_q  <= S_NDIV;
					end
				end
				S_NDIV: begin
					if (div_done) begin
						if (div_quo == word_t'(1)) begin
							strobe_q   <= 1'b1;
							solvable_q <= 1'b1;
							solution_q <= '0;
							state_q    <= S_IDLE;
						end else begin
							div_go_q <= 1'b1;
							state_q  <= S_RED;
						end
					end
				end
				S_RED: begin
					if (div_done) begin
						div_go_q <= 1'b1;
						state_q  <= S_EUC;
					end
				end
				S_EUC: begin
					if (div_done) begin
						mul_go_q <= 1'b1;
						state_q  <= S_MUL;
					end
				end
				S_MUL: begin
					if (mul_done) begin
						div_go_q <= 1'b1;
						state_q  <= (r_q == '0) ? S_BRED : S_EUC;
					end
				end
				S_BRED: begin
					if (div_done) begin
						mul_go_q <= 1'b1;
						state_q  <= S_FIN;
					end
				end
				S_FIN: begin
					if (mul_done) begin
						strobe_q   <= 1'b1;
						solvable_q <= 1'b1;
						solution_q <= mul_res;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers and unit operands
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				a_q     <= coef;
				b_q     <= rhs;
				n_q     <= modulus;
				y_q     <= modulus;
				div_a_q <= coef;
				div_b_q <= modulus;
			end
			S_GCD: begin
				if (div_done) begin
					if (div_rem == '0) begin
						div_a_q <= b_q;
						div_b_q <= y_q;
					end else begin
						y_q     <= div_rem;
						div_a_q <= y_q;
						div_b_q <= div_rem;
					end
				end
			end
			S_BDIV: begin
				if (div_done) begin
					rb_q    <= div_quo;
					div_a_q <= a_q;
				end
			end
			S_ADIV: begin
				if (div_done) begin
					ra_q    <= div_quo;
					div_a_q <= n_q;
				end
			end
			S_NDIV: begin
				if (div_done) begin
					m_q     <= div_quo;
					div_a_q <= ra_q;
					div_b_q <= div_quo;
				end
			end
			S_RED: begin
				if (div_done) begin
					or_q    <= div_rem;
					r_q     <= m_q;
					os_q    <= word_t'(1);
					s_q     <= '0;
					div_a_q <= div_rem;
					div_b_q <= m_q;
				end
			end
			S_EUC: begin
				if (div_done) begin
					or_q    <= r_q;
					r_q     <= div_rem;
					mul_x_q <= div_quo;
					mul_y_q <= s_q;
				end
			end
			S_MUL: begin
				if (mul_done) begin
					os_q <= s_q;
					s_q  <= new_s;
					if (r_q == '0) begin
						div_a_q <= rb_q;
						div_b_q <= m_q;
					end else begin
						div_a_q <= or_q;
						div_b_q <= r_q;
					end
				end
			end
			S_BRED: begin
				if (div_done) begin
					mul_x_q <= div_rem;
					mul_y_q <= os_q;
				end
			end
			S_FIN: begin
			end
			default: begin
			end
		endcase
	end

	assign busy     = (state_q != S_IDLE);
	assign strobe   = strobe_q;
	assign solvable = solvable_q;
	assign solution = solution_q;
endmodule

[tb/sv/linear_congruence_solver_top_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// linear_congruence_solver_top_tb
// drives random and corner-case congruences into the solver and compares
// every result with a predicted solution computed inside the testbench
// ---------------------------------------------------------------------------
module linear_congruence_solver_top_tb;
	import lcs_pkg::*;

	typedef struct {
		logic  ok;
		word_t x;
	} answer_t;

	class congruence_board;
		answer_t pending[$];
		int      errors;

		static function longint unsigned gcd_of(longint unsigned p, longint unsigned q);
			longint unsigned t;
			while (q != 0) begin
				t = p % q;
				p = q;
				q = t;
			end
			return p;
		endfunction

		static function longint unsigned inverse_of(longint unsigned p, longint unsigned m);
			longint r0, r1, s0, s1, q, t;
			r0 = longint'(p % m);
			r1 = longint'(m);
			s0 = 1;
			s1 = 0;
			while (r1 != 0) begin
				q  = r0 / r1;
				t  = r0 - q * r1;
				r0 = r1;
				r1 = t;
				t  = s0 - q * s1;
				s0 = s1;
				s1 = t;
			end
			t = s0 % longint'(m);
			if (t < 0)
				t += longint'(m);
			return unsigned'(t);
		endfunction

		function void note_request(word_t a, word_t b, word_t n);
			answer_t         e;
			longint unsigned d, rb, rn;
			e.ok = 0;
			e.x  = '0;
			if (n != 0) begin
				d = gcd_of(a, n);
				if ((b % d) == 0) begin
					e.ok = 1;
					rb   = b / d;
					rn   = n / d;
					if (rn != 1)
						e.x = word_t'(((rb % rn) * inverse_of(a / d, rn)) % rn);
				end
			end
			pending = {pending, e};
		endfunction

		function void check_result(logic ok, word_t x);
			answer_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result solvable=%0d solution=%0d", ok, x);
				return;
			end
			e = pending.pop_front();
			if (ok !== e.ok || x !== e.x) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected %0d/%0d got %0d/%0d", e.ok, e.x, ok, x);
			end
		endfunction
	endclass

	logic  clk, arst_n, start, busy, strobe, solvable;
	word_t coef, rhs, modulus, solution;
	congruence_board board;
	bit    quiet;
	int    cycles;

	linear_congruence_solver_top i_dut (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 10000000) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && strobe)
			board.check_result(solvable, solution);

	function automatic word_t rand_word();
		case ($urandom_range(0, 5))
			0: return word_t'($urandom_range(0, 20));
			1: return word_t'($urandom_range(0, 1000));
			2: return '1 - word_t'($urandom_range(0, 3));
			default: return word_t'($urandom);
		endcase
	endfunction

	task automatic send_request(word_t a, word_t b, word_t n);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1;
		coef    <= a;
		rhs     <= b;
		modulus <= n;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note_request(a, b, n);
	endtask

	initial begin
		word_t a, b, n, k;
		board  = new();
		cycles = 0;
		quiet  = 0;
		arst_n = 0;
		start  = 0;
		coef   = '0;
		rhs    = '0;
		modulus = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_request('0, '0, '0);
		send_request('1, '1, '0);
		send_request('0, 12, 4);
		send_request('0, 13, 4);
		send_request('0, '0, '1);
		send_request('1, '1, '1);
		send_request('1, '1, '1 - 1);
		send_request('1 - 1, '1, '1);
		send_request(3, 5, 7);
		send_request(6, 9, 15);
		send_request(6, 10, 15);
		send_request(5, 7, 1);
		send_request(8, 4, 4);
		send_request(32'h8000_0000, 32'h8000_0000, '1);
		send_request('1, 32'h5555_5555, 32'hAAAA_AAAA);
		send_request(32'hAAAA_AAAA, 32'h5555_5555, '1);
		send_request(1836311903, 1, 2971215073);

		for (int i = 0; i < 300; i++) begin
			if (i > 260)
				quiet = 1;
			a = rand_word();
			n = rand_word();
			if ($urandom_range(0, 9) == 0)
				n = '0;
			if ($urandom_range(0, 2) == 0) begin
				k = word_t'($urandom_range(1, 64));
				a = a * k;
				n = n * k;
				b = ($urandom_range(0, 1)) ? rand_word() * k : rand_word();
			end else
				b = rand_word();
			send_request(a, b, n);
		end
		start <= 0;

		while (board.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (board.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
